// ===== rtl/serial_line_editor_echo_macros.svh =====
// ----------------------------------------------------------------------------
// Serial line editor assertion macros
// Shared assertion forms for the serial line editor checker.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_EDITOR_ECHO_MACROS_SVH
`define SERIAL_LINE_EDITOR_ECHO_MACROS_SVH

// check a property outside reset
`define SLE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every edge, reset included
`define SLE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial line editor package
// Payload types, command codes and character constants.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int CFG_IDX_W = 1;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  localparam logic [7:0] MAX_LENGTH_RST  = 8'd32;
  localparam logic [7:0] DRAIN_TICKS_RST = 8'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_LENGTH  = 1'b0,
    CFG_DRAIN_TICKS = 1'b1
  } sle_cfg_t;

  typedef enum logic [1:0] {
    OP_CHAR  = 2'd0,
    OP_LINE  = 2'd1,
    OP_ERASE = 2'd2
  } sle_op_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } sle_req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_char;
    logic       erase;
    logic       line_done;
    logic [7:0] line_length;
    logic       last;
  } sle_rsp_t;

  typedef struct packed {
    sle_op_t    op;
    logic [7:0] ch;
    logic [7:0] pos;
    logic [7:0] len;
  } sle_cmd_t;

  typedef struct packed {
    logic     push;
    sle_cmd_t cmd;
  } sle_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sle_qstat_t;

endpackage

// ===== rtl/sle_queue.sv =====
// ----------------------------------------------------------------------------
// Serial line editor command queue
// Short FIFO of echo commands between the front and back ends.
// ----------------------------------------------------------------------------
module sle_queue import sle_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  sle_push_t  wr,
  input  logic       pop,
  output sle_cmd_t   head,
  output sle_qstat_t stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sle_cmd_t          mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wr_ptr] <= wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (wr.push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !wr.push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/sle_front.sv =====
// ----------------------------------------------------------------------------
// Serial line editor front end
// Accepts bytes and ticks, keeps line length and drain window, issues
// echo commands.
// ----------------------------------------------------------------------------
module sle_front import sle_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  sle_req_t             req_data,
  output logic                 req_stall,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  sle_qstat_t           qstat,
  output sle_push_t            wr
);

  logic [7:0] max_length;
  logic [7:0] drain_ticks;
  logic [7:0] current_length;
  logic [7:0] current_length_next;
  logic [7:0] drain_remaining;
  logic [7:0] drain_remaining_next;
  logic       accept;
  logic [7:0] ch;

  assign req_stall = qstat.full;
  assign accept    = req_valid && !qstat.full;
  assign ch        = req_data.rx_byte;

  always_comb begin
    current_length_next  = current_length;
    drain_remaining_next = drain_remaining;
    wr.push              = 1'b0;
    wr.cmd.op            = OP_CHAR;
    wr.cmd.ch            = ch;
    wr.cmd.pos           = current_length;
    wr.cmd.len           = current_length;
    priority if (req_data.req_type) begin
      if (drain_remaining != 8'd0) begin
        drain_remaining_next = drain_remaining - 8'd1;
      end
    end else if (drain_remaining != 8'd0) begin
      drain_remaining_next = 8'd0;
    end else if (ch == CH_CR || ch == CH_LF) begin
      wr.push              = accept;
      wr.cmd.op            = OP_LINE;
      current_length_next  = 8'd0;
      drain_remaining_next = drain_ticks;
    end else if (ch == CH_BS || ch == CH_DEL) begin
      if (current_length != 8'd0) begin
        wr.push             = accept;
        wr.cmd.op           = OP_ERASE;
        wr.cmd.len          = current_length - 8'd1;
        current_length_next = current_length - 8'd1;
      end
    end else if (ch >= CH_SP && ch < CH_DEL && current_length < max_length) begin
      wr.push             = accept;
      wr.cmd.op           = OP_CHAR;
      wr.cmd.len          = current_length + 8'd1;
      current_length_next = current_length + 8'd1;
    end else begin
      // drop: line full, control byte or high byte
      current_length_next = current_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length      <= MAX_LENGTH_RST;
      drain_ticks     <= DRAIN_TICKS_RST;
      current_length  <= 8'd0;
      drain_remaining <= 8'd0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MAX_LENGTH:  max_length  <= cfg_data;
          CFG_DRAIN_TICKS: drain_ticks <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        current_length  <= current_length_next;
        drain_remaining <= drain_remaining_next;
      end
    end
  end

endmodule

// ===== rtl/sle_back.sv =====
// ----------------------------------------------------------------------------
// Serial line editor back end
// Expands each echo command into its result beats behind an output register.
// ----------------------------------------------------------------------------
module sle_back import sle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  sle_cmd_t   head,
  input  sle_qstat_t qstat,
  output logic       pop,
  output logic       rsp_valid,
  output sle_rsp_t   rsp_data,
  input  logic       rsp_stall
);

  sle_cmd_t   cur;
  logic       cur_valid;
  logic [1:0] step;
  sle_rsp_t   beat;
  logic       load;
  logic       take;
  logic       done_cur;

  always_comb begin
    beat             = '0;
    beat.line_length = cur.len;
    unique case (cur.op)
      OP_CHAR: begin
        beat.tx_byte     = cur.ch;
        beat.store_valid = 1'b1;
        beat.store_index = cur.pos;
        beat.store_char  = cur.ch;
        beat.last        = 1'b1;
      end
      OP_LINE: begin
        beat.tx_byte   = (step == 2'd0) ? CH_CR : CH_LF;
        beat.line_done = (step != 2'd0);
        beat.last      = (step != 2'd0);
      end
      OP_ERASE: begin
        beat.tx_byte = (step == 2'd1) ? CH_SP : CH_BS;
        beat.erase   = (step == 2'd0);
        beat.last    = (step == 2'd2);
      end
      default: begin
        beat.last = 1'b1;
      end
    endcase
  end

  assign load     = !rsp_valid || !rsp_stall;
  assign take     = cur_valid && load;
  assign done_cur = take && beat.last;
  assign pop      = !qstat.empty && (!cur_valid || done_cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      cur_valid <= 1'b0;
      step      <= 2'd0;
    end else begin
      if (load) begin
        rsp_valid <= cur_valid;
      end
      if (take) begin
        step <= beat.last ? 2'd0 : step + 2'd1;
      end
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (done_cur) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp_data <= beat;
    end
    if (pop) begin
      cur <= head;
    end
  end

endmodule

// ===== rtl/serial_line_editor_echo.sv =====
// ----------------------------------------------------------------------------
// Serial line editor with echo
// Edits one console line from received bytes and timer ticks and returns
// the echo beats.
//
//   channel  direction  handshake           beat
//   req      in         req_valid/stall     sle_req_t (byte or tick)
//   rsp      out        rsp_valid/stall     sle_rsp_t (one echo byte)
//   cfg      in         cfg_valid/ready     index + data, always ready
//
// The front end takes one item per cycle while the queue has room.
// The back end sends one beat per cycle while commands wait and rsp_stall is
// low: a printable byte gives one beat, a line end two (CR, LF) and an erase
// byte three (BS, SP, BS); ticks and dropped bytes give no beat.
// Reset clears the line and drain window and loads max_length 32 and
// drain_ticks 20. rsp_stall holds the output beat; req_stall rises only when
// the command queue is full.
// ----------------------------------------------------------------------------
module serial_line_editor_echo import sle_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  sle_req_t             req_data,
  output logic                 req_stall,
  output logic                 rsp_valid,
  output sle_rsp_t             rsp_data,
  input  logic                 rsp_stall,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  sle_push_t  wr;
  sle_qstat_t qstat;
  sle_cmd_t   head;
  logic       pop;

  assign cfg_ready = 1'b1;

  sle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_data  (req_data),
    .req_stall (req_stall),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .wr        (wr)
  );

  sle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .pop  (pop),
    .head (head),
    .stat (qstat)
  );

  sle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data),
    .rsp_stall (rsp_stall)
  );

endmodule

// ===== rtl/sle_checker.sv =====
// ----------------------------------------------------------------------------
// Serial line editor checker
// Port-level assertions on the echo stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "serial_line_editor_echo_macros.svh"

module sle_checker import sle_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     rsp_valid,
  input sle_rsp_t rsp_data,
  input logic     rsp_stall
);

  `SLE_ASSERT_ALWAYS(a_rst_quiet, rst |=> !rsp_valid, "beat right after reset")

  `SLE_ASSERT(a_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data),
              "stalled beat changed")

  `SLE_ASSERT(a_erase_first,
              rsp_valid && rsp_data.erase |-> !rsp_data.last && rsp_data.tx_byte == CH_BS,
              "bad erase beat")

  `SLE_ASSERT(a_store,
              rsp_valid && rsp_data.store_valid |-> rsp_data.last &&
              rsp_data.store_index + 8'd1 == rsp_data.line_length,
              "bad store beat")

  `SLE_ASSERT(a_line_done,
              rsp_valid && rsp_data.line_done |-> rsp_data.last && rsp_data.tx_byte == CH_LF,
              "bad line end beat")

endmodule

bind serial_line_editor_echo sle_checker u_sle_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_data  (rsp_data),
  .rsp_stall (rsp_stall)
);

// ===== verif/tb_serial_line_editor_echo.sv =====
// ----------------------------------------------------------------------------
// Serial line editor echo testbench
// Sends received bytes and timer ticks through the request channel, tracks
// the console line and drain window alongside the block, and checks every
// echo beat against the predicted one. Directed tests cover printable
// bytes, erasing, ignored bytes, line ends with and without a drain window,
// and length limits; random editing sessions follow under three idling mixes.
// ----------------------------------------------------------------------------
module tb_serial_line_editor_echo;
  import sle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  sle_req_t             req_data = '0;
  logic                 req_stall;
  logic                 rsp_valid;
  sle_rsp_t             rsp_data;
  logic                 rsp_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  int req_gap_pct = 27;
  int rsp_hold_pct = 63;
  int mismatches = 0;

  logic [7:0] max_len_cfg = MAX_LENGTH_RST;
  logic [7:0] drain_cfg = DRAIN_TICKS_RST;
  logic [7:0] line_len = '0;
  logic [7:0] drain_left = '0;
  sle_rsp_t   pending_echo[$];

  serial_line_editor_echo u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_data  (req_data),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data),
    .rsp_stall (rsp_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < rsp_hold_pct);
  end

  function automatic sle_rsp_t echo_beat(logic [7:0] tx, logic stored, logic [7:0] pos,
                                         logic er, logic done, logic [7:0] len,
                                         logic fin);
    sle_rsp_t b;
    b.tx_byte     = tx;
    b.store_valid = stored;
    b.store_index = stored ? pos : 8'd0;
    b.store_char  = stored ? tx : 8'd0;
    b.erase       = er;
    b.line_done   = done;
    b.line_length = len;
    b.last        = fin;
    return b;
  endfunction

  function automatic void edit_line_model(sle_req_t r);
    logic [7:0] ch;
    ch = r.rx_byte;
    if (r.req_type == REQ_TICK) begin
      if (drain_left != 0) drain_left = drain_left - 8'd1;
      return;
    end
    if (drain_left != 0) begin
      drain_left = '0;
      return;
    end
    if (ch == CH_CR || ch == CH_LF) begin
      pending_echo.push_back(echo_beat(CH_CR, 1'b0, 8'd0, 1'b0, 1'b0, line_len, 1'b0));
      pending_echo.push_back(echo_beat(CH_LF, 1'b0, 8'd0, 1'b0, 1'b1, line_len, 1'b1));
      line_len   = '0;
      drain_left = drain_cfg;
    end else if (ch == CH_BS || ch == CH_DEL) begin
      if (line_len != 0) begin
        line_len = line_len - 8'd1;
        pending_echo.push_back(echo_beat(CH_BS, 1'b0, 8'd0, 1'b1, 1'b0, line_len, 1'b0));
        pending_echo.push_back(echo_beat(CH_SP, 1'b0, 8'd0, 1'b0, 1'b0, line_len, 1'b0));
        pending_echo.push_back(echo_beat(CH_BS, 1'b0, 8'd0, 1'b0, 1'b0, line_len, 1'b1));
      end
    end else if (ch >= CH_SP && ch < CH_DEL && line_len < max_len_cfg) begin
      pending_echo.push_back(echo_beat(ch, 1'b1, line_len, 1'b0, 1'b0, line_len + 8'd1,
                                       1'b1));
      line_len = line_len + 8'd1;
    end
  endfunction

  always @(posedge clk) begin
    sle_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_echo.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected beat: tx %h sv %b idx %0d ch %h er %b done %b len %0d last %b",
                   rsp_data.tx_byte, rsp_data.store_valid, rsp_data.store_index,
                   rsp_data.store_char, rsp_data.erase, rsp_data.line_done,
                   rsp_data.line_length, rsp_data.last);
      end else begin
        want = pending_echo.pop_front();
        if (rsp_data !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("beat mismatch at %0t", $realtime);
            $display("  expected: tx %h sv %b idx %0d ch %h er %b done %b len %0d last %b",
                     want.tx_byte, want.store_valid, want.store_index, want.store_char,
                     want.erase, want.line_done, want.line_length, want.last);
            $display("  actual:   tx %h sv %b idx %0d ch %h er %b done %b len %0d last %b",
                     rsp_data.tx_byte, rsp_data.store_valid, rsp_data.store_index,
                     rsp_data.store_char, rsp_data.erase, rsp_data.line_done,
                     rsp_data.line_length, rsp_data.last);
          end
        end
      end
    end
  end

  task automatic send_item(logic kind, logic [7:0] b);
    sle_req_t r;
    r.req_type = kind;
    r.rx_byte  = b;
    if ($urandom_range(0, 99) < req_gap_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < req_gap_pct);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    edit_line_model(r);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (pending_echo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(sle_cfg_t idx, logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_MAX_LENGTH) max_len_cfg = v;
    else drain_cfg = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_printable_echo();
    send_item(REQ_BYTE, CH_SP);
    send_item(REQ_BYTE, CH_TILDE);
  endtask

  task automatic test_erase_and_ignored();
    send_item(REQ_BYTE, 8'h00);
    send_item(REQ_BYTE, 8'hFF);
    send_item(REQ_BYTE, CH_BS);
    send_item(REQ_BYTE, CH_DEL);
    send_item(REQ_BYTE, CH_DEL);
  endtask

  task automatic test_line_end_drain();
    send_item(REQ_BYTE, "x");
    send_item(REQ_BYTE, CH_CR);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_BYTE, "q");
    settle();
    write_reg(CFG_DRAIN_TICKS, 8'd0);
    send_item(REQ_BYTE, CH_LF);
    send_item(REQ_BYTE, "y");
    settle();
    write_reg(CFG_DRAIN_TICKS, 8'd1);
    send_item(REQ_BYTE, CH_CR);
    send_item(REQ_TICK, 8'hFF);
    send_item(REQ_BYTE, "z");
  endtask

  task automatic test_line_limits();
    send_item(REQ_BYTE, "a");
    send_item(REQ_BYTE, "b");
    settle();
    write_reg(CFG_MAX_LENGTH, 8'd1);
    send_item(REQ_BYTE, "c");
    send_item(REQ_BYTE, CH_BS);
    settle();
    write_reg(CFG_MAX_LENGTH, 8'd0);
    send_item(REQ_BYTE, "d");
    settle();
    write_reg(CFG_MAX_LENGTH, 8'd255);
    write_reg(CFG_DRAIN_TICKS, 8'd255);
    send_item(REQ_BYTE, CH_CR);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_BYTE, "e");
  endtask

  task automatic test_random_edit(int n, int gap_pct, int hold_pct);
    int pick;
    settle();
    case ($urandom_range(0, 3))
      0: write_reg(CFG_MAX_LENGTH, 8'd255);
      1: write_reg(CFG_MAX_LENGTH, 8'($urandom_range(9, 40)));
      default: write_reg(CFG_MAX_LENGTH, 8'($urandom_range(1, 8)));
    endcase
    write_reg(CFG_DRAIN_TICKS, 8'($urandom_range(0, 4)));
    req_gap_pct  = gap_pct;
    rsp_hold_pct = hold_pct;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) send_item(REQ_BYTE, 8'($urandom_range(CH_SP, CH_TILDE)));
      else if (pick < 62) send_item(REQ_BYTE, $urandom_range(0, 1) ? CH_BS : CH_DEL);
      else if (pick < 72) send_item(REQ_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF);
      else if (pick < 88) send_item(REQ_TICK, 8'($urandom_range(0, 255)));
      else send_item(REQ_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_printable_echo();
    test_erase_and_ignored();
    test_line_end_drain();
    test_line_limits();
    test_random_edit(48, 27, 63);
    test_random_edit(48, 63, 27);
    test_random_edit(48, 0, 0);
    settle();
    mismatches += pending_echo.size();
    if (mismatches == 0)
      $display("serial_line_editor_echo regression: pass");
    else
      $display("serial_line_editor_echo regression: fail");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("serial_line_editor_echo regression: fail");
    $finish;
  end

endmodule
